FILE: hw/rtl/centered_median_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Centered median filter assertion macros
// Shared concurrent assertion forms used by the filter modules.
// ----------------------------------------------------------------------------
`ifndef CENTERED_MEDIAN_FILTER_UNIT_MACROS_SVH
`define CENTERED_MEDIAN_FILTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered median filter package
// Sample widths, register constants and the transaction and control types.
// ----------------------------------------------------------------------------
package cmf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int HALF_BITS = 3;
   localparam int MAX_HALF_DEFAULT = 7;
   localparam logic [HALF_BITS-1:0] HALF_RESET = 3'd1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] median;
      logic                          last_out;
   } rsp_type;

   typedef struct packed {
      logic                          ins_en;
      logic                          del_en;
      logic                          clear_en;
      logic signed [SAMPLE_BITS-1:0] ins_value;
   } op_type;

endpackage

FILE: hw/rtl/cmf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered median filter sorting cell
// Holds one sample and its age; takes a value from a neighbor or the new sample.
// ----------------------------------------------------------------------------
module cmf_cell #(
   parameter int AGE_W = $clog2(2 * cmf_pkg::MAX_HALF_DEFAULT + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cmf_pkg::op_type                        op,
   input  logic [AGE_W-1:0]                       del_age,
   input  logic                                   gone_in,
   output logic                                   gone_out,
   input  logic signed [cmf_pkg::SAMPLE_BITS-1:0] lower_value,
   input  logic [AGE_W-1:0]                       lower_age,
   input  logic                                   lower_valid,
   input  logic                                   lower_ge,
   input  logic signed [cmf_pkg::SAMPLE_BITS-1:0] upper_value,
   input  logic [AGE_W-1:0]                       upper_age,
   input  logic                                   upper_valid,
   input  logic                                   upper_ge,
   output logic signed [cmf_pkg::SAMPLE_BITS-1:0] value_out,
   output logic [AGE_W-1:0]                       age_out,
   output logic                                   valid_out,
   output logic                                   ge_out
);

   logic signed [cmf_pkg::SAMPLE_BITS-1:0] value_ff, value_in, new_value, lo_value, hi_value;
   logic [AGE_W-1:0] age_ff, age_in, lo_age, hi_age;
   logic valid_ff, valid_in, lo_valid, hi_valid, lo_ge, hi_ge, del_here;

   assign new_value = op.ins_value;
   assign del_here = op.del_en && valid_ff && (age_ff == del_age);
   assign gone_out = gone_in || del_here;
   assign ge_out = !valid_ff || (value_ff > new_value);

   always_comb begin
      lo_value = gone_in ? value_ff : lower_value;
      lo_age = gone_in ? age_ff : lower_age;
      lo_valid = gone_in ? valid_ff : lower_valid;
      lo_ge = gone_in ? ge_out : lower_ge;
      hi_value = gone_out ? upper_value : value_ff;
      hi_age = gone_out ? upper_age : age_ff;
      hi_valid = gone_out ? upper_valid : valid_ff;
      hi_ge = gone_out ? upper_ge : ge_out;

      if (op.clear_en) begin
         valid_in = 1'b0;
         value_in = value_ff;
         age_in = age_ff;
      end else if (op.ins_en && lo_ge) begin
         valid_in = lo_valid;
         value_in = lo_value;
         age_in = lo_age + AGE_W'(1);
      end else if (op.ins_en && hi_ge) begin
         valid_in = 1'b1;
         value_in = new_value;
         age_in = '0;
      end else begin
         valid_in = hi_valid;
         value_in = hi_value;
         age_in = hi_age + AGE_W'(op.ins_en);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff <= age_in;
   end

   assign value_out = value_ff;
   assign age_out = age_ff;
   assign valid_out = valid_ff;

endmodule

FILE: hw/rtl/cmf_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered median filter cell chain
// A sorted row of cells that inserts and evicts samples and selects a rank.
// ----------------------------------------------------------------------------
`include "centered_median_filter_unit_macros.svh"

module cmf_chain #(
   parameter int MAX_HALF = cmf_pkg::MAX_HALF_DEFAULT,
   parameter int DEPTH = 2 * MAX_HALF + 1,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cmf_pkg::op_type                        op,
   input  logic [IDX_W-1:0]                       del_age,
   input  logic [IDX_W-1:0]                       med_index,
   output logic signed [cmf_pkg::SAMPLE_BITS-1:0] median
);

   logic signed [cmf_pkg::SAMPLE_BITS-1:0] value_w [DEPTH];
   logic [IDX_W-1:0] age_w [DEPTH];
   logic valid_w [DEPTH];
   logic ge_w [DEPTH];
   logic gone_w [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [cmf_pkg::SAMPLE_BITS-1:0] lower_value, upper_value;
      logic [IDX_W-1:0] lower_age, upper_age;
      logic lower_valid, lower_ge, upper_valid, upper_ge, gone_in;

      if (i == 0) begin : g_first
         assign lower_value = '0;
         assign lower_age = '0;
         assign lower_valid = 1'b0;
         assign lower_ge = 1'b0;
         assign gone_in = 1'b0;
      end else begin : g_inner_lo
         assign lower_value = value_w[i-1];
         assign lower_age = age_w[i-1];
         assign lower_valid = valid_w[i-1];
         assign lower_ge = ge_w[i-1];
         assign gone_in = gone_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper_value = '0;
         assign upper_age = '0;
         assign upper_valid = 1'b0;
         assign upper_ge = 1'b1;
      end else begin : g_inner_hi
         assign upper_value = value_w[i+1];
         assign upper_age = age_w[i+1];
         assign upper_valid = valid_w[i+1];
         assign upper_ge = ge_w[i+1];
      end

      cmf_cell #(
         .AGE_W(IDX_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .del_age    (del_age),
         .gone_in    (gone_in),
         .gone_out   (gone_w[i]),
         .lower_value(lower_value),
         .lower_age  (lower_age),
         .lower_valid(lower_valid),
         .lower_ge   (lower_ge),
         .upper_value(upper_value),
         .upper_age  (upper_age),
         .upper_valid(upper_valid),
         .upper_ge   (upper_ge),
         .value_out  (value_w[i]),
         .age_out    (age_w[i]),
         .valid_out  (valid_w[i]),
         .ge_out     (ge_w[i])
      );
   end

   assign median = value_w[med_index];

   `CMF_ASSERT_IMPLIES(a_del_hits, clock, reset, op.del_en, gone_w[DEPTH-1], "Eviction found no cell with the requested age.")
   `CMF_ASSERT_IMPLIES(a_ins_room, clock, reset, op.ins_en && !op.del_en, !valid_w[DEPTH-1], "Insertion into a full chain.")

   for (genvar k = 0; k < DEPTH - 1; k++) begin : g_order
      `CMF_ASSERT_IMPLIES(a_sorted, clock, reset, valid_w[k+1], valid_w[k] && (value_w[k] <= value_w[k+1]), "Chain is not packed and sorted.")
   end

endmodule

FILE: hw/rtl/centered_median_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered median filter unit
// Gives the median of a centered window of 2h+1 samples, cut at stream ends.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  req     | in        | req_valid / req_stall  | req_item (sample, last)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_item (median, last_out)
//  csr     | in        | csr_write_en           | csr_write_data (half-width)
//
// A sample that yields no result is inserted into the sorted cell chain; one that
// yields a result is inserted and then rank-selected into the result register.
// A last sample also flushes the results still due, up to h+1 in all.
// After the half-width is lowered, the next sample first evicts the oldest samples
// until the window fits. Reset empties the chain and sets h to 1.
// While rsp_stall holds back a pending result, the result register holds and the flush waits.
// ----------------------------------------------------------------------------
`include "centered_median_filter_unit_macros.svh"

module centered_median_filter_unit #(
   parameter int MAX_HALF = cmf_pkg::MAX_HALF_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cmf_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cmf_pkg::rsp_type                rsp_item,
   input  logic                            csr_write_en,
   input  logic [cmf_pkg::HALF_BITS-1:0]   csr_write_data
);

   localparam int DEPTH = 2 * MAX_HALF + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int HW = $clog2(MAX_HALF + 1);
   localparam int CNT_W = HW + 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_TRIM = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [cmf_pkg::HALF_BITS-1:0] half_window_ff, half_window_in;
   logic [HW-1:0] h_ff, h_in, j_ff, j_in, eff_half, h_cur, ins_jstart;
   logic [CNT_W-1:0] cnt_ff, cnt_in, len_cur, ins_cnt, flush_keep;
   logic signed [cmf_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in, ins_sample, median;
   logic last_ff, last_in, ins_last, ins_full, ins_due;
   logic rsp_valid_ff, rsp_valid_in;
   cmf_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic req_accept, out_free, emit_load;
   cmf_pkg::op_type op;
   logic [IDX_W-1:0] del_age, med_index;

   assign req_stall = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign half_window_in = csr_write_en ? csr_write_data : half_window_ff;

   always_comb begin
      if (half_window_ff == '0) begin
         eff_half = HW'(1);
      end else if (32'(half_window_ff) > MAX_HALF) begin
         eff_half = HW'(MAX_HALF);
      end else begin
         eff_half = HW'(half_window_ff);
      end
   end

   assign h_cur = (state_ff == S_IDLE) ? eff_half : h_ff;
   assign len_cur = {h_cur, 1'b1};
   assign ins_sample = (state_ff == S_IDLE) ? req_item.sample : sample_ff;
   assign ins_last = (state_ff == S_IDLE) ? req_item.last : last_ff;
   assign ins_full = (cnt_ff == len_cur);
   assign ins_cnt = ins_full ? cnt_ff : cnt_ff + CNT_W'(1);
   assign ins_due = ins_last || (ins_cnt > CNT_W'(h_cur));
   assign ins_jstart = (ins_cnt > CNT_W'(h_cur)) ? '0
                     : HW'(CNT_W'(h_cur) + CNT_W'(1) - ins_cnt);
   assign flush_keep = len_cur - CNT_W'(j_ff) - CNT_W'(1);
   assign del_age = IDX_W'(cnt_ff - CNT_W'(1));
   assign med_index = IDX_W'(cnt_ff >> 1);

   always_comb begin
      logic do_insert;
      do_insert = 1'b0;
      state_in = state_ff;
      h_in = h_ff;
      j_in = j_ff;
      cnt_in = cnt_ff;
      sample_in = sample_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in = rsp_item_ff;
      emit_load = 1'b0;
      op = '0;
      op.ins_value = ins_sample;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               h_in = eff_half;
               sample_in = req_item.sample;
               last_in = req_item.last;
               if (cnt_ff > len_cur) begin
                  state_in = S_TRIM;
               end else begin
                  do_insert = 1'b1;
               end
            end
         end
         S_TRIM: begin
            if (cnt_ff > len_cur) begin
               op.del_en = 1'b1;
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               do_insert = 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit_load = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_item_in.median = median;
               rsp_item_in.last_out = last_ff && (j_ff == h_ff);
               if (!last_ff) begin
                  state_in = S_IDLE;
               end else if (j_ff == h_ff) begin
                  op.clear_en = 1'b1;
                  cnt_in = '0;
                  state_in = S_IDLE;
               end else begin
                  if (cnt_ff > flush_keep) begin
                     op.del_en = 1'b1;
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
                  j_in = j_ff + HW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_insert) begin
         op.ins_en = 1'b1;
         op.del_en = ins_full;
         cnt_in = ins_cnt;
         j_in = ins_jstart;
         state_in = ins_due ? S_EMIT : S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         half_window_ff <= cmf_pkg::HALF_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         half_window_ff <= half_window_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      j_ff <= j_in;
      sample_ff <= sample_in;
      last_ff <= last_in;
      rsp_item_ff <= rsp_item_in;
   end

   cmf_chain #(
      .MAX_HALF(MAX_HALF)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .del_age  (del_age),
      .med_index(med_index),
      .median   (median)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   `CMF_ASSERT_IMPLIES(a_emit_nonempty, clock, reset, emit_load, cnt_ff != '0, "Result taken from an empty window.")
   `CMF_ASSERT_NEXT(a_last_clears, clock, reset, emit_load && rsp_item_in.last_out, cnt_ff == '0, "Window not emptied after the final result.")
   `CMF_ASSERT_IMPLIES(a_trim_bound, clock, reset, state_ff == S_TRIM, cnt_ff >= len_cur, "Window trimmed below its length.")
   `CMF_ASSERT_IMPLIES(a_flush_index, clock, reset, state_ff == S_EMIT, j_ff <= h_ff, "Flush position beyond the half-width.")

endmodule

FILE: test/centered_median_filter_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered median filter result checker
// Watches the sample, result and register ports of the filter. It keeps its
// own copy of the sample ring, the stream count and the half-width, works out
// the medians that each accepted sample transaction releases, and compares
// every accepted result transaction field by field with the oldest of them.
// ----------------------------------------------------------------------------
module centered_median_filter_unit_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  cmf_pkg::req_type              req_item,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  cmf_pkg::rsp_type              rsp_item,
   input  logic                          csr_write_en,
   input  logic [cmf_pkg::HALF_BITS-1:0] csr_write_data,
   output int                            fail_count,
   output int                            outstanding
);
   import cmf_pkg::*;

   localparam int unsigned MAX_HALF = MAX_HALF_DEFAULT;
   localparam int unsigned RING_DEPTH = 2 * MAX_HALF + 1;

   logic signed [SAMPLE_BITS-1:0] sample_ring [RING_DEPTH];
   int unsigned                   ring_slot;
   int unsigned                   stream_count;
   logic [HALF_BITS-1:0]          half_width;
   rsp_type                       pending_medians [$];
   rsp_type                       due;
   int                            fails = 0;

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] recent_median(int unsigned count);
      logic signed [SAMPLE_BITS-1:0] sorted [RING_DEPTH];
      logic signed [SAMPLE_BITS-1:0] value;
      int unsigned                   idx;
      int                            pos;
      for (int i = 0; i < count; i++) begin
         idx = (ring_slot + RING_DEPTH - 1 - i) % RING_DEPTH;
         value = sample_ring[idx];
         pos = i;
         while (pos > 0 && sorted[pos-1] > value) begin
            sorted[pos] = sorted[pos-1];
            pos--;
         end
         sorted[pos] = value;
      end
      return sorted[count / 2];
   endfunction

   task automatic filter_sample(req_type item);
      int unsigned half;
      int unsigned span;
      int unsigned flush_max;
      int unsigned count;
      rsp_type     result;
      half = (half_width == 0) ? 1 : half_width;
      if (half > MAX_HALF) half = MAX_HALF;
      span = 2 * half + 1;
      if (ring_slot >= RING_DEPTH) ring_slot = 0;
      sample_ring[ring_slot] = item.sample;
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      if (stream_count < span) stream_count++;
      else stream_count = span;
      flush_max = item.last ? half : 0;
      for (int unsigned j = 0; j <= flush_max; j++) begin
         if (stream_count + j > half) begin
            count = (stream_count < span - j) ? stream_count : span - j;
            result.median = recent_median(count);
            result.last_out = item.last && (j == half);
            pending_medians.push_back(result);
         end
      end
      if (item.last) begin
         stream_count = 0;
         ring_slot = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ring_slot = 0;
         stream_count = 0;
         half_width = HALF_RESET;
         pending_medians.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_medians.size() == 0) begin
               $display("%0t: unexpected result transaction, median %0d last_out %0b",
                        $time, $signed(rsp_item.median), rsp_item.last_out);
               fails++;
            end else begin
               due = pending_medians.pop_front();
               if (rsp_item.median !== due.median) begin
                  $display("%0t: median expected %0d, actual %0d",
                           $time, $signed(due.median), $signed(rsp_item.median));
                  fails++;
               end
               if (rsp_item.last_out !== due.last_out) begin
                  $display("%0t: last_out expected %0b, actual %0b",
                           $time, due.last_out, rsp_item.last_out);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) filter_sample(req_item);
         if (csr_write_en) half_width = csr_write_data;
      end
      fail_count <= fails;
      outstanding <= pending_medians.size();
   end

endmodule

FILE: test/centered_median_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered median filter testbench
// Drives streams of samples through the filter under a series of half-width
// settings, with random gaps on the sample side and random stalls on the
// result side, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module centered_median_filter_unit_tb;
   import cmf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_item;
   logic                 csr_write_en = 1'b0;
   logic [HALF_BITS-1:0] csr_write_data = HALF_RESET;
   logic                 calm = 1'b0;
   int                   fail_count;
   int                   outstanding;
   int                   cycles = 0;
   int                   stall_left = 0;
   int                   run_left = 0;

   always #1 clock = ~clock;

   centered_median_filter_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   centered_median_filter_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("centered_median_filter_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         run_left = $urandom_range(0, 20);
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return SAMPLE_BITS'($urandom);
         5, 6, 7: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
         8: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         default: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      endcase
   endfunction

   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] sample, logic last);
      int gap;
      req_valid <= 1'b1;
      req_item.sample <= sample;
      req_item.last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_half(logic [HALF_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int budget;
      int stream_len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'shffff, 1'b0);
      send_sample(16'sh0005, 1'b1);
      send_sample(16'sh8000, 1'b1);
      drain();
      write_half(3'd7);
      // A stream shorter than the half-width still gets one result per sample.
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh0001, 1'b0);
      send_sample(16'sh8000, 1'b1);
      for (int i = 0; i < 10; i++) begin
         send_sample(i[0] ? 16'sh7fff : 16'sh8000, 1'b0);
      end
      drain();
      // The half-width is lowered in the middle of a stream.
      write_half(3'd2);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh7ffe, 1'b0);
      send_sample(16'sh8001, 1'b0);
      send_sample(16'sh0003, 1'b1);
      drain();
      write_half(3'd0);
      send_sample(16'sh0002, 1'b0);
      send_sample(16'shfffe, 1'b0);
      send_sample(16'sh0000, 1'b1);

      for (int phase = 0; phase < 10; phase++) begin
         drain();
         case (phase)
            0: write_half(3'd7);
            1: write_half(3'd0);
            2: write_half(3'd1);
            default: write_half(HALF_BITS'($urandom_range(0, 7)));
         endcase
         if (phase == 9) calm <= 1'b1;
         budget = 24;
         while (budget > 0) begin
            stream_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                     : $urandom_range(5, 30);
            for (int k = 0; k < stream_len && budget > 0; k++) begin
               send_sample(random_sample(), k == stream_len - 1);
               budget--;
            end
         end
      end
      send_sample(random_sample(), 1'b1);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("centered_median_filter_unit: match");
      end else begin
         $display("centered_median_filter_unit: mismatch");
      end
      $finish;
   end

endmodule
